// File: hw/rtl/crc32rd_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the record deframer.
// No dependencies.
package crc32rd_pkg;

  localparam int LEN_W = 26;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] MIN_LEN  = 32'd4;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(33554432);

  typedef logic [2:0] status_t;
  localparam status_t ST_BUSY      = 3'd0;
  localparam status_t ST_GOOD      = 3'd1;
  localparam status_t ST_BAD_LEN   = 3'd2;
  localparam status_t ST_CRC_ERR   = 3'd3;
  localparam status_t ST_TRUNCATED = 3'd4;
  localparam status_t ST_CLEAN_END = 3'd5;

  typedef struct packed {
    logic             valid;
    logic [7:0]       payload_byte;
    logic             payload_valid;
    logic             last;
    status_t          status;
    logic [LEN_W-1:0] record_length;
  } result_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] v);
    logic [31:0] c;
    c = c_in ^ {24'd0, v};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/crc32rd_if.sv
// Valid/ready channel interfaces for the record deframer input and result streams.
// Depends on crc32rd_pkg.
interface crc32rd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface crc32rd_out_if
  import crc32rd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [7:0]       payload_byte;
  logic             payload_valid;
  logic             last;
  status_t          status;
  logic [LEN_W-1:0] record_length;

  modport source (output valid, payload_byte, payload_valid, last, status, record_length,
                  input ready);
  modport sink   (input valid, payload_byte, payload_valid, last, status, record_length,
                  output ready);
endinterface

// File: hw/rtl/crc32_record_deframer.sv
// Top level of the length/CRC-32 framed record deframer.
// Depends on crc32rd_pkg, crc32rd_if, crc32rd_core and crc32rd_out_reg.
//
// Takes one stream byte or end-of-stream mark per input transfer, every cycle. The whole
// per-byte step (header byte capture, length check, one byte of CRC-32) sits between the
// input handshake and the result register, so the input stays ready whenever that
// register is empty or is being taken in the same cycle. Header bytes give no result but
// for a rejected length; each payload byte gives one, and the last one carries good or
// CRC mismatch. Size errors, CRC mismatches and truncation stop the block: inputs are
// then taken and dropped until reset. The max_record_length register is written through
// cfg_wr_en/cfg_wr_data; the user must do so only while idle, unchecked by the block.
module crc32_record_deframer
  import crc32rd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  crc32rd_in_if.sink       in_ch,
  crc32rd_out_if.source    out_ch
);

  logic    acc;
  result_t res;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  crc32rd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .kind        (in_ch.kind),
    .data_byte   (in_ch.data_byte),
    .res         (res)
  );

  crc32rd_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (acc),
    .res    (res),
    .out_ch (out_ch)
  );

endmodule

// File: hw/rtl/crc32rd_core.sv
// Header parsing, length check, running CRC and record sequencing; one byte per transfer.
// Depends on crc32rd_pkg.
module crc32rd_core
  import crc32rd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             acc,
  input  logic             kind,
  input  logic [7:0]       data_byte,
  output result_t          res
);

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_CRC  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;
  localparam logic [1:0] PH_HALT = 2'd3;

  logic [LEN_W-1:0] max_len;
  logic [1:0]       phase, phase_next;
  logic [1:0]       hdr_cnt, hdr_cnt_next;
  logic [31:0]      length_word, length_word_next;
  logic [31:0]      expected_crc, expected_crc_next;
  logic [31:0]      running_crc, running_crc_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;

  logic [31:0]      byte_sh;
  logic [31:0]      lw_new;
  logic [31:0]      crc_new;
  logic [LEN_W-1:0] left_dec;
  logic             len_bad;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] cur_len;

  assign byte_sh  = {24'd0, data_byte} << {hdr_cnt, 3'b000};
  assign lw_new   = length_word | byte_sh;
  assign crc_new  = crc_byte(running_crc, data_byte);
  assign left_dec = bytes_left - LEN_W'(1);
  assign len_bad  = (lw_new < MIN_LEN) || (lw_new > {{(32-LEN_W){1'b0}}, max_len});
  assign len_sat  = (|lw_new[31:LEN_W]) ? {LEN_W{1'b1}} : lw_new[LEN_W-1:0];
  assign cur_len  = length_word[LEN_W-1:0];

  always_comb begin
    phase_next        = phase;
    hdr_cnt_next      = hdr_cnt;
    length_word_next  = length_word;
    expected_crc_next = expected_crc;
    running_crc_next  = running_crc;
    bytes_left_next   = bytes_left;
    res               = '0;

    if (phase != PH_HALT) begin
      if (kind) begin
        res.valid = 1'b1;
        res.last  = 1'b1;
        if (phase == PH_LEN && hdr_cnt == 2'd0) begin
          res.status = ST_CLEAN_END;
        end else begin
          res.status        = ST_TRUNCATED;
          res.record_length = (phase == PH_LEN) ? '0 : cur_len;
          phase_next        = PH_HALT;
        end
      end else begin
        case (phase)
          PH_LEN: begin
            length_word_next = lw_new;
            hdr_cnt_next     = hdr_cnt + 2'd1;
            if (hdr_cnt == 2'd3) begin
              if (len_bad) begin
                res.valid         = 1'b1;
                res.last          = 1'b1;
                res.status        = ST_BAD_LEN;
                res.record_length = len_sat;
                phase_next        = PH_HALT;
              end else begin
                phase_next        = PH_CRC;
                expected_crc_next = '0;
              end
            end
          end
          PH_CRC: begin
            expected_crc_next = expected_crc | byte_sh;
            hdr_cnt_next      = hdr_cnt + 2'd1;
            if (hdr_cnt == 2'd3) begin
              phase_next       = PH_PAY;
              running_crc_next = CRC_INIT;
              bytes_left_next  = cur_len;
            end
          end
          PH_PAY: begin
            running_crc_next  = crc_new;
            bytes_left_next   = left_dec;
            res.valid         = 1'b1;
            res.payload_byte  = data_byte;
            res.payload_valid = 1'b1;
            res.record_length = cur_len;
            if (left_dec == '0) begin
              res.last = 1'b1;
              if ((crc_new ^ CRC_INIT) == expected_crc) begin
                res.status        = ST_GOOD;
                phase_next        = PH_LEN;
                hdr_cnt_next      = 2'd0;
                length_word_next  = '0;
                expected_crc_next = '0;
                running_crc_next  = CRC_INIT;
              end else begin
                res.status = ST_CRC_ERR;
                phase_next = PH_HALT;
              end
            end else begin
              res.status = ST_BUSY;
            end
          end
          default: begin
            phase_next = PH_HALT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len      <= MAX_LEN_RESET;
      phase        <= PH_LEN;
      hdr_cnt      <= 2'd0;
      length_word  <= '0;
      expected_crc <= '0;
      running_crc  <= CRC_INIT;
      bytes_left   <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (acc) begin
        phase        <= phase_next;
        hdr_cnt      <= hdr_cnt_next;
        length_word  <= length_word_next;
        expected_crc <= expected_crc_next;
        running_crc  <= running_crc_next;
        bytes_left   <= bytes_left_next;
      end
    end
  end

endmodule

// File: hw/rtl/crc32rd_out_reg.sv
// Result register: holds one result until the downstream transfer completes.
// Depends on crc32rd_pkg and crc32rd_if.
module crc32rd_out_reg
  import crc32rd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  result_t              res,
  crc32rd_out_if.source        out_ch
);

  logic             valid;
  logic [7:0]       payload_byte;
  logic             payload_valid;
  logic             last;
  status_t          status;
  logic [LEN_W-1:0] record_length;

  // load only happens when the register is empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= res.valid;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      payload_byte  <= res.payload_byte;
      payload_valid <= res.payload_valid;
      last          <= res.last;
      status        <= res.status;
      record_length <= res.record_length;
    end
  end

  assign out_ch.valid         = valid;
  assign out_ch.payload_byte  = payload_byte;
  assign out_ch.payload_valid = payload_valid;
  assign out_ch.last          = last;
  assign out_ch.status        = status;
  assign out_ch.record_length = record_length;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for crc32_record_deframer: framed records, clean ends, one halting error.
// Depends on crc32rd_pkg, crc32rd_if and the deframer RTL.
module tb;
  import crc32rd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEM_TARGET = 1100;
  localparam int QUIET_TAIL = 150;
  localparam logic [LEN_W-1:0] MAX_LEN_TOP = '1;

  typedef enum logic [1:0] {PH_LENGTH, PH_CHECKSUM, PH_PAYLOAD, PH_HALTED} rx_phase_t;

  typedef struct {
    logic [7:0]       pay_byte;
    logic             pay_valid;
    logic             last;
    status_t          status;
    logic [LEN_W-1:0] rec_len;
  } deframe_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  crc32rd_in_if  in_ch ();
  crc32rd_out_if out_ch ();

  crc32_record_deframer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // deframer state as predicted
  rx_phase_t        ph;
  logic [1:0]       hdr_count;
  logic [31:0]      len_word;
  logic [31:0]      crc_want;
  logic [31:0]      crc_run;
  logic [LEN_W-1:0] bytes_left;
  logic [LEN_W-1:0] pr_max_len;

  deframe_result_t  expected_results[$];
  int               mismatches;
  int               items_sent;
  int               quiet_cycles;
  bit               idling;
  logic [LEN_W-1:0] max_len_setting;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Bit-serial reflected CRC-32 step over one byte, lsb first.
  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ d[i]}});
    end
    return c;
  endfunction

  function automatic bit predict_deframe(input logic k, input logic [7:0] b,
                                         output deframe_result_t r);
    logic [31:0] shifted;
    r = '{pay_byte: '0, pay_valid: 1'b0, last: 1'b0, status: ST_BUSY, rec_len: '0};
    shifted = 32'(b) << (8 * hdr_count);
    if (ph == PH_HALTED) return 1'b0;
    if (k) begin
      r.last = 1'b1;
      if (ph == PH_LENGTH && hdr_count == 2'd0) begin
        r.status = ST_CLEAN_END;
        return 1'b1;
      end
      r.status = ST_TRUNCATED;
      r.rec_len = (ph == PH_LENGTH) ? '0 : len_word[LEN_W-1:0];
      ph = PH_HALTED;
      return 1'b1;
    end
    case (ph)
      PH_LENGTH: begin
        len_word = len_word | shifted;
        hdr_count = hdr_count + 2'd1;
        if (hdr_count != 2'd0) return 1'b0;
        if (len_word < MIN_LEN || len_word > 32'(pr_max_len)) begin
          r.last = 1'b1;
          r.status = ST_BAD_LEN;
          r.rec_len = (len_word > 32'(MAX_LEN_TOP)) ? MAX_LEN_TOP : len_word[LEN_W-1:0];
          ph = PH_HALTED;
          return 1'b1;
        end
        ph = PH_CHECKSUM;
        crc_want = '0;
        return 1'b0;
      end
      PH_CHECKSUM: begin
        crc_want = crc_want | shifted;
        hdr_count = hdr_count + 2'd1;
        if (hdr_count != 2'd0) return 1'b0;
        ph = PH_PAYLOAD;
        crc_run = CRC_INIT;
        bytes_left = len_word[LEN_W-1:0];
        return 1'b0;
      end
      default: begin
        crc_run = crc32_update(crc_run, b);
        bytes_left = bytes_left - LEN_W'(1);
        r.pay_byte = b;
        r.pay_valid = 1'b1;
        r.rec_len = len_word[LEN_W-1:0];
        if (bytes_left != '0) return 1'b1;
        r.last = 1'b1;
        if (~crc_run == crc_want) begin
          r.status = ST_GOOD;
          ph = PH_LENGTH;
          hdr_count = '0;
          len_word = '0;
          crc_want = '0;
          crc_run = CRC_INIT;
        end else begin
          r.status = ST_CRC_ERR;
          ph = PH_HALTED;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    deframe_result_t want;
    deframe_result_t got;
    if (rst) begin
      ph = PH_LENGTH;
      hdr_count = '0;
      len_word = '0;
      crc_want = '0;
      crc_run = CRC_INIT;
      bytes_left = '0;
      pr_max_len = MAX_LEN_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.payload_byte, out_ch.payload_valid, out_ch.last, out_ch.status,
                out_ch.record_length};
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual byte %0h status %0d",
                   $time, got.pay_byte, got.status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("payload_byte", 32'(want.pay_byte), 32'(got.pay_byte));
          check_field("payload_valid", 32'(want.pay_valid), 32'(got.pay_valid));
          check_field("last", 32'(want.last), 32'(got.last));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("record_length", 32'(want.rec_len), 32'(got.rec_len));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_deframe(in_ch.kind, in_ch.data_byte, want)) expected_results.push_back(want);
      end
      if (cfg_wr_en) pr_max_len = cfg_wr_data;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result-side backpressure in bursts
  always begin
    @(negedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    out_ch.ready <= 1'b1;
  end

  task automatic send_item(input logic k, input logic [7:0] b);
    @(negedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.data_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // Sends length, CRC and payload; cut >= 0 replaces that item with end of stream.
  task automatic send_record(input logic [31:0] rec_len, input logic [31:0] crc_flip,
                             input int cut, input int fill);
    logic [7:0]  pay[$];
    logic [31:0] crc;
    int          n;
    n = (rec_len > 512) ? 512 : int'(rec_len);
    crc = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      pay.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      crc = crc32_update(crc, pay[i]);
    end
    crc = ~crc ^ crc_flip;
    for (int i = 0; i < n + 8; i++) begin
      if (i == cut) begin
        send_item(1'b1, 8'($urandom));
        return;
      end
      if (i < 4) send_item(1'b0, rec_len[8*i +: 8]);
      else if (i < 8) send_item(1'b0, crc[8*(i-4) +: 8]);
      else send_item(1'b0, pay[i-8]);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    // header bytes leave nothing to wait on; give the pipeline time to settle
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    max_len_setting = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int length_cap();
    return (max_len_setting < 40) ? int'(max_len_setting) : 40;
  endfunction

  task automatic test_clean_end();
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'hFF);
  endtask

  task automatic test_short_records();
    send_record(32'd4, '0, -1, 8'h00);
    write_max_len(LEN_W'(4));
    send_record(32'd4, '0, -1, 8'hFF);
  endtask

  task automatic test_random_records();
    int records;
    int cap;
    records = 0;
    while (items_sent < ITEM_TARGET) begin
      if (records % 6 == 0) begin
        case (records / 6)
          0: write_max_len(MAX_LEN_TOP);
          1: write_max_len(MAX_LEN_RESET);
          default: begin
            case ($urandom_range(0, 3))
              0: write_max_len(LEN_W'(4));
              1: write_max_len(LEN_W'($urandom_range(5, 40)));
              2: write_max_len(MAX_LEN_RESET);
              default: write_max_len(MAX_LEN_TOP);
            endcase
          end
        endcase
      end
      idling = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom));
      cap = length_cap();
      if (max_len_setting >= 300 && $urandom_range(0, 19) == 0) cap = 300;
      send_record(32'($urandom_range(4, cap)), '0, -1, -1);
      records++;
    end
    idling = 1'b0;
  endtask

  // One halting error per run; the seed picks which.
  task automatic test_terminal_error();
    int len;
    len = $urandom_range(4, length_cap());
    case ($urandom_range(0, 7))
      0: send_record(32'($urandom_range(0, 3)), '0, -1, -1);
      1: begin
        write_max_len(LEN_W'($urandom_range(4, 30)));
        send_record(32'(max_len_setting) + 32'($urandom_range(1, 4)), '0, -1, -1);
      end
      2: send_record({6'($urandom_range(1, 63)), 26'($urandom)}, '0, -1, -1);
      3: send_record(32'(len), 32'($urandom) | 32'h1, -1, -1);
      4: send_record(32'(len), '0, $urandom_range(1, 3), -1);
      5: send_record(32'(len), '0, $urandom_range(4, 7), -1);
      6: send_record(32'(len), '0, $urandom_range(8, 7 + len), -1);
      default: begin
        // a limit below the minimum length rejects every record
        write_max_len(LEN_W'($urandom_range(0, 3)));
        send_record(32'($urandom_range(4, 20)), '0, -1, -1);
      end
    endcase
  endtask

  task automatic test_halted_inputs();
    repeat (24) send_item(1'($urandom), 8'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    idling = 1'b0;
    items_sent = 0;
    mismatches = 0;
    quiet_cycles = 0;
    max_len_setting = MAX_LEN_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clean_end();
    test_short_records();
    test_random_records();
    test_terminal_error();
    test_halted_inputs();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/crc32rd_pkg.sv
hw/rtl/crc32rd_if.sv
hw/rtl/crc32rd_core.sv
hw/rtl/crc32rd_out_reg.sv
hw/rtl/crc32_record_deframer.sv
tb/tb.sv
